[sv/tnaa_pkg.sv]
// Package for the triangle normal and area block: shared constants and types.
// No dependencies.
`default_nettype none
package tnaa_pkg;

  // Default vertex coordinate width.
  localparam int COORD_BITS_DEF = 16;
  // Fraction bits of the unit normal components.
  localparam int FRAC_BITS = 14;
  // Bits of one result normal component.
  localparam int NRM_W = 16;
  // Bits of the normal quotient magnitude before the sign is applied.
  localparam int QW = FRAC_BITS + 1;
  // Magnitudes used for the normal are brought below 2^NORM_BITS.
  localparam int NORM_BITS = 34;
  // Sum of the three squared normal magnitudes.
  localparam int SN_W = 2 * NORM_BITS + 2;
  // Signed working width of the normal quotient stages.
  localparam int EW = SN_W + 2 * FRAC_BITS + 6;
  // Bits of the doubled area result.
  localparam int AREA_BITS = 36;

  // Per-item flags that travel beside the arithmetic.
  typedef struct packed {
    logic       degenerate;
    logic [2:0] neg;
  } side_t;

endpackage
`default_nettype wire

[sv/tnaa_if.sv]
// Handshake interfaces for the triangle input and the result output.
// Depends on tnaa_pkg.
`default_nettype none
interface tnaa_tri_if #(parameter int COORD_BITS = tnaa_pkg::COORD_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] a_z;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] b_z;
  logic signed [COORD_BITS-1:0] c_x;
  logic signed [COORD_BITS-1:0] c_y;
  logic signed [COORD_BITS-1:0] c_z;
  logic                         reverse_order;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  reverse_order, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                reverse_order, output ready);
endinterface

interface tnaa_res_if ();
  logic                                 valid;
  logic                                 ready;
  logic signed [tnaa_pkg::NRM_W-1:0]    normal_x;
  logic signed [tnaa_pkg::NRM_W-1:0]    normal_y;
  logic signed [tnaa_pkg::NRM_W-1:0]    normal_z;
  logic        [tnaa_pkg::AREA_BITS-1:0] double_area;
  logic                                 degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, double_area, degenerate,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, double_area, degenerate,
                output ready);
endinterface
`default_nettype wire

[sv/tnaa_front.sv]
// Front pipeline: edges, cross product, magnitudes, squares and quotient setup.
// Depends on tnaa_pkg.
`default_nettype none
module tnaa_front #(
  parameter int COORD_BITS = tnaa_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [COORD_BITS-1:0]           a_x,
  input  logic signed [COORD_BITS-1:0]           a_y,
  input  logic signed [COORD_BITS-1:0]           a_z,
  input  logic signed [COORD_BITS-1:0]           b_x,
  input  logic signed [COORD_BITS-1:0]           b_y,
  input  logic signed [COORD_BITS-1:0]           b_z,
  input  logic signed [COORD_BITS-1:0]           c_x,
  input  logic signed [COORD_BITS-1:0]           c_y,
  input  logic signed [COORD_BITS-1:0]           c_z,
  input  logic                                   reverse_order,
  output logic                                   out_valid,
  output logic        [4*COORD_BITS+7:0]         s_a,
  output logic        [tnaa_pkg::SN_W-1:0]       s_n,
  output logic signed [tnaa_pkg::EW-1:0]         e0 [3],
  output tnaa_pkg::side_t                        side
);
  import tnaa_pkg::*;

  localparam int E_W    = COORD_BITS + 1;
  localparam int P_W    = 2 * COORD_BITS + 2;
  localparam int MAG_W  = 2 * COORD_BITS + 3;
  localparam int MAGX_W = (MAG_W > NORM_BITS) ? MAG_W : NORM_BITS;
  localparam int SH_W   = $clog2(MAGX_W - NORM_BITS + 2);
  localparam int LO_A   = (MAG_W + 1) / 2;
  localparam int HI_A   = MAG_W - LO_A;
  localparam int LO_N   = NORM_BITS / 2;
  localparam int HI_N   = NORM_BITS - LO_N;
  localparam int SA_W   = 2 * MAG_W + 2;

  logic [8:1] vld;

  logic signed [COORD_BITS-1:0] va [3];
  logic signed [COORD_BITS-1:0] vb [3];
  logic signed [COORD_BITS-1:0] vc [3];

  logic signed [E_W-1:0]      ab [3];
  logic signed [E_W-1:0]      cb [3];
  logic signed [P_W-1:0]      prod [6];
  logic signed [MAG_W-1:0]    nvec [3];
  logic        [MAG_W-1:0]    mag3 [3];
  side_t                      side3, side4, side5, side6, side7;
  logic        [MAG_W-1:0]    mag4 [3];
  logic        [NORM_BITS-1:0] m4 [3];
  logic        [2*HI_A-1:0]   ahh [3];
  logic        [HI_A+LO_A-1:0] ahl [3];
  logic        [2*LO_A-1:0]   all5 [3];
  logic        [2*HI_N-1:0]   nhh [3];
  logic        [HI_N+LO_N-1:0] nhl [3];
  logic        [2*LO_N-1:0]   nll [3];
  logic        [2*MAG_W-1:0]  asq [3];
  logic        [2*NORM_BITS-1:0] nsq6 [3];
  logic        [2*NORM_BITS-1:0] nsq7 [3];
  logic        [SA_W-1:0]     sa7;
  logic        [SN_W-1:0]     sn7;

  logic [MAGX_W-1:0] orv;
  logic [SH_W-1:0]   sh;
  logic [MAGX_W-1:0] magx [3];

  assign va = '{a_x, a_y, a_z};
  assign vb = '{b_x, b_y, b_z};
  assign vc = '{c_x, c_y, c_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:1], in_valid};
    end
  end

  // Stage 1: edges from the shared corner, after the optional swap.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ab[j] <= E_W'(va[j]) - E_W'(reverse_order ? vc[j] : vb[j]);
        cb[j] <= E_W'(reverse_order ? vb[j] : vc[j]) - E_W'(reverse_order ? vc[j] : vb[j]);
      end
    end
  end

  // Stage 2: the six cross-product terms.
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= cb[1] * ab[2];
      prod[1] <= cb[2] * ab[1];
      prod[2] <= cb[2] * ab[0];
      prod[3] <= cb[0] * ab[2];
      prod[4] <= cb[0] * ab[1];
      prod[5] <= cb[1] * ab[0];
    end
  end

  // Stage 3: cross product, signs and magnitudes.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nvec[j] = MAG_W'(prod[2*j]) - MAG_W'(prod[2*j+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mag3[j]      <= nvec[j][MAG_W-1] ? MAG_W'(-nvec[j]) : MAG_W'(nvec[j]);
        side3.neg[j] <= nvec[j][MAG_W-1];
      end
      side3.degenerate <= (nvec[0] == '0) && (nvec[1] == '0) && (nvec[2] == '0);
    end
  end

  // Stage 4: bring the magnitudes used for the normal below 2^NORM_BITS.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      magx[j] = MAGX_W'(mag3[j]);
    end
    orv = magx[0] | magx[1] | magx[2];
    sh  = '0;
    for (int p = NORM_BITS; p < MAGX_W; p++) begin
      if (orv[p]) begin
        sh = SH_W'(p - NORM_BITS + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mag4[j] <= mag3[j];
        m4[j]   <= NORM_BITS'(magx[j] >> sh);
      end
      side4 <= side3;
    end
  end

  // Stage 5: partial products of the squares.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ahh[j]  <= mag4[j][MAG_W-1:LO_A] * mag4[j][MAG_W-1:LO_A];
        ahl[j]  <= mag4[j][MAG_W-1:LO_A] * mag4[j][LO_A-1:0];
        all5[j] <= mag4[j][LO_A-1:0] * mag4[j][LO_A-1:0];
        nhh[j]  <= m4[j][NORM_BITS-1:LO_N] * m4[j][NORM_BITS-1:LO_N];
        nhl[j]  <= m4[j][NORM_BITS-1:LO_N] * m4[j][LO_N-1:0];
        nll[j]  <= m4[j][LO_N-1:0] * m4[j][LO_N-1:0];
      end
      side5 <= side4;
    end
  end

  // Stage 6: squares.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        asq[j]  <= ((2*MAG_W)'(ahh[j]) << (2*LO_A)) + ((2*MAG_W)'(ahl[j]) << (LO_A+1))
                   + (2*MAG_W)'(all5[j]);
        nsq6[j] <= ((2*NORM_BITS)'(nhh[j]) << (2*LO_N)) + ((2*NORM_BITS)'(nhl[j]) << (LO_N+1))
                   + (2*NORM_BITS)'(nll[j]);
      end
      side6 <= side5;
    end
  end

  // Stage 7: sums of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      sa7  <= SA_W'(asq[0]) + SA_W'(asq[1]) + SA_W'(asq[2]);
      sn7  <= SN_W'(nsq6[0]) + SN_W'(nsq6[1]) + SN_W'(nsq6[2]);
      nsq7 <= nsq6;
      side7 <= side6;
    end
  end

  // Stage 8: starting remainders of the quotient stages, m^2 * 2^30 - s.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        e0[j] <= $signed(EW'(nsq7[j]) << (2*FRAC_BITS+2)) - $signed(EW'(sn7));
      end
      s_a  <= sa7;
      s_n  <= sn7;
      side <= side7;
    end
  end

  assign out_valid = vld[8];

endmodule
`default_nettype wire

[sv/tnaa_sqrt.sv]
// Pipelined integer square root, one result bit per stage, for the doubled area.
// Depends on tnaa_pkg.
`default_nettype none
module tnaa_sqrt #(
  parameter int COORD_BITS = tnaa_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [4*COORD_BITS+7:0]   s_a,
  output logic [2*COORD_BITS+3:0]   root
);
  import tnaa_pkg::*;

  localparam int SA_W = 4 * COORD_BITS + 8;
  localparam int R_W  = 2 * COORD_BITS + 4;
  localparam int TW   = SA_W + 2;

  logic [TW-1:0]  rem_q  [R_W];
  logic [R_W-1:0] root_q [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam int B = R_W - 1 - k;
    logic [TW-1:0]  rem_i;
    logic [R_W-1:0] root_i;
    logic [TW-1:0]  trial;
    logic           fits;

    if (k == 0) begin : g_first
      assign rem_i  = TW'(s_a);
      assign root_i = '0;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    assign trial = (TW'(root_i) << (B + 1)) | (TW'(1) << (2 * B));
    assign fits  = rem_i >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= fits ? rem_i - trial : rem_i;
        root_q[k] <= fits ? (root_i | (R_W'(1) << B)) : root_i;
      end
    end
  end

  assign root = root_q[R_W-1];

endmodule
`default_nettype wire

[sv/tnaa_unit.sv]
// Pipelined rounded quotient m * 2^14 / sqrt(s) for the three normal components,
// one quotient bit per stage, then alignment stages. Depends on tnaa_pkg.
`default_nettype none
module tnaa_unit #(
  parameter int COORD_BITS = tnaa_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic        [tnaa_pkg::SN_W-1:0] s_n,
  input  logic signed [tnaa_pkg::EW-1:0] e0 [3],
  input  tnaa_pkg::side_t                side_in,
  output logic                           out_valid,
  output logic        [tnaa_pkg::QW-1:0] q [3],
  output tnaa_pkg::side_t                side_out
);
  import tnaa_pkg::*;

  localparam int NSTG = FRAC_BITS + 1;
  localparam int R_W  = 2 * COORD_BITS + 4;
  localparam int DLY  = R_W - NSTG;

  logic                  v_q  [NSTG];
  side_t                 sd_q [NSTG];
  logic [SN_W-1:0]       s_q  [NSTG];
  logic signed [EW-1:0]  e_q  [NSTG][3];
  logic signed [EW-1:0]  p_q  [NSTG][3];
  logic [QW-1:0]         q_q  [NSTG][3];

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    localparam int B = FRAC_BITS - k;
    logic                 v_i;
    side_t                sd_i;
    logic [SN_W-1:0]      s_i;
    logic signed [EW-1:0] sx;
    logic signed [EW-1:0] e_i [3];
    logic signed [EW-1:0] p_i [3];
    logic [QW-1:0]        q_i [3];
    logic signed [EW-1:0] t   [3];

    if (k == 0) begin : g_first
      assign v_i  = in_valid;
      assign sd_i = side_in;
      assign s_i  = s_n;
      assign e_i  = e0;
      // P tracks s * (2q - 1); with q = 0 it is -s.
      assign p_i  = '{-sx, -sx, -sx};
      assign q_i  = '{'0, '0, '0};
    end else begin : g_next
      assign v_i  = v_q[k-1];
      assign sd_i = sd_q[k-1];
      assign s_i  = s_q[k-1];
      assign e_i  = e_q[k-1];
      assign p_i  = p_q[k-1];
      assign q_i  = q_q[k-1];
    end

    assign sx = $signed(EW'(s_i));

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        t[j] = e_i[j] - (p_i[j] <<< (B + 2)) - (sx <<< (2 * B + 2));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_q[k] <= sd_i;
        s_q[k]  <= s_i;
        for (int j = 0; j < 3; j++) begin
          if (!t[j][EW-1]) begin
            e_q[k][j] <= t[j];
            p_q[k][j] <= p_i[j] + (sx <<< (B + 1));
            q_q[k][j] <= q_i[j] | (QW'(1) << B);
          end else begin
            e_q[k][j] <= e_i[j];
            p_q[k][j] <= p_i[j];
            q_q[k][j] <= q_i[j];
          end
        end
      end
    end
  end

  // Alignment with the area square root.
  logic          dv_q  [DLY];
  side_t         dsd_q [DLY];
  logic [QW-1:0] dq_q  [DLY][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < DLY; d++) begin
        dv_q[d] <= 1'b0;
      end
    end else if (en) begin
      dv_q[0] <= v_q[NSTG-1];
      for (int d = 1; d < DLY; d++) begin
        dv_q[d] <= dv_q[d-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsd_q[0] <= sd_q[NSTG-1];
      dq_q[0]  <= q_q[NSTG-1];
      for (int d = 1; d < DLY; d++) begin
        dsd_q[d] <= dsd_q[d-1];
        dq_q[d]  <= dq_q[d-1];
      end
    end
  end

  assign out_valid = dv_q[DLY-1];
  assign side_out  = dsd_q[DLY-1];
  assign q         = dq_q[DLY-1];

endmodule
`default_nettype wire

[sv/triangle_normal_and_area_top.sv]
// Top level of the triangle unit normal and doubled area block.
// Depends on tnaa_pkg, tnaa_if, tnaa_front, tnaa_sqrt and tnaa_unit.
//
//   Channel  | Dir | Interface    | Transaction
//   ---------+-----+--------------+----------------------------------------------
//   tri_in   | in  | tnaa_tri_if  | three vertices a, b, c and reverse_order
//   res_out  | out | tnaa_res_if  | normal_x/y/z (Q2.14), double_area, degenerate
//
// One transaction can enter in every cycle while tri_in.ready is high. The path runs
// through eight front stages, the square root that produces one area bit per stage,
// and the output register.
// Reset (rst, synchronous) empties the pipeline and the output buffer.
// When res_out stalls, one extra result is caught in a skid register; only then
// does tri_in.ready drop and the whole pipeline hold, so nothing is lost or repeated.
`default_nettype none
module triangle_normal_and_area_top #(
  parameter int COORD_BITS = tnaa_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tnaa_tri_if.sink    tri_in,
  tnaa_res_if.source  res_out
);
  import tnaa_pkg::*;

  localparam int R_W  = 2 * COORD_BITS + 4;
  localparam int SA_W = 4 * COORD_BITS + 8;
  localparam int AX_W = (R_W > AREA_BITS) ? R_W : AREA_BITS + 1;

  // The pipeline moves only while the skid register is free.
  logic en;

  logic                 f_valid;
  logic [SA_W-1:0]      f_sa;
  logic [SN_W-1:0]      f_sn;
  logic signed [EW-1:0] f_e0 [3];
  side_t                f_side;

  logic [R_W-1:0]       root;
  logic                 u_valid;
  logic [QW-1:0]        u_q [3];
  side_t                u_side;

  tnaa_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (tri_in.valid),
    .a_x           (tri_in.a_x),
    .a_y           (tri_in.a_y),
    .a_z           (tri_in.a_z),
    .b_x           (tri_in.b_x),
    .b_y           (tri_in.b_y),
    .b_z           (tri_in.b_z),
    .c_x           (tri_in.c_x),
    .c_y           (tri_in.c_y),
    .c_z           (tri_in.c_z),
    .reverse_order (tri_in.reverse_order),
    .out_valid     (f_valid),
    .s_a           (f_sa),
    .s_n           (f_sn),
    .e0            (f_e0),
    .side          (f_side)
  );

  tnaa_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .s_a  (f_sa),
    .root (root)
  );

  tnaa_unit #(.COORD_BITS(COORD_BITS)) u_unit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .s_n       (f_sn),
    .e0        (f_e0),
    .side_in   (f_side),
    .out_valid (u_valid),
    .q         (u_q),
    .side_out  (u_side)
  );

  // Final formatting: apply signs, force a degenerate triangle to a zero normal,
  // and saturate the area.
  logic signed [NRM_W-1:0]  nrm [3];
  logic [AX_W-1:0]          rootx;
  logic [AREA_BITS-1:0]     area;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (u_side.degenerate) begin
        nrm[j] = '0;
      end else if (u_side.neg[j]) begin
        nrm[j] = -$signed(NRM_W'(u_q[j]));
      end else begin
        nrm[j] = $signed(NRM_W'(u_q[j]));
      end
    end
    rootx = AX_W'(root);
    area  = (|rootx[AX_W-1:AREA_BITS]) ? '1 : rootx[AREA_BITS-1:0];
  end

  // Output register plus skid register.
  logic                    out_valid;
  logic                    skid_valid;
  logic signed [NRM_W-1:0] out_nrm [3];
  logic signed [NRM_W-1:0] skid_nrm [3];
  logic [AREA_BITS-1:0]    out_area, skid_area;
  logic                    out_degen, skid_degen;
  logic                    out_free;
  logic                    push;

  assign en       = !skid_valid;
  assign out_free = !out_valid || res_out.ready;
  assign push     = u_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_nrm   <= skid_nrm;
        out_area  <= skid_area;
        out_degen <= skid_degen;
      end else begin
        out_nrm   <= nrm;
        out_area  <= area;
        out_degen <= u_side.degenerate;
      end
    end else if (push) begin
      skid_nrm   <= nrm;
      skid_area  <= area;
      skid_degen <= u_side.degenerate;
    end
  end

  assign tri_in.ready        = en;
  assign res_out.valid       = out_valid;
  assign res_out.normal_x    = out_nrm[0];
  assign res_out.normal_y    = out_nrm[1];
  assign res_out.normal_z    = out_nrm[2];
  assign res_out.double_area = out_area;
  assign res_out.degenerate  = out_degen;

`ifndef SYNTHESIS
  // The skid register only ever holds a result behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output is empty");

  // The skid register fills when a result arrives while the output is stalled.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (!skid_valid && push && out_valid && !res_out.ready) |=> skid_valid)
    else $error("result from the pipeline was not caught by the skid register");

  // A degenerate result carries a zero normal and zero area.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_degen) |-> (out_area == '0 && out_nrm[0] == '0 &&
                                  out_nrm[1] == '0 && out_nrm[2] == '0))
    else $error("degenerate result with nonzero normal or area");
`endif

endmodule
`default_nettype wire
